FILE: design/lkt_pkg.sv
// Package with the shared constants and types of the LRU key tracker.
package lkt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned CapW       = 5;
  localparam int unsigned FillW      = 5;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CapW-1:0]        cap_t;
  typedef logic [FillW-1:0]       fill_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef struct packed {
    key_t key;
    logic upd;
    logic hit;
    logic evict;
  } bcast_t;

  typedef struct packed {
    logic  hit;
    logic  evict_valid;
    key_t  evicted_key;
    fill_t fill_count;
  } res_t;

endpackage

FILE: design/lkt_if.sv
// Interfaces for the input and result channels of the LRU key tracker.
interface lkt_in_if;
  logic          valid;
  logic          ready;
  lkt_pkg::key_t ref_key;

  modport source (output valid, output ref_key, input ready);
  modport sink (input valid, input ref_key, output ready);
endinterface

interface lkt_out_if;
  logic           valid;
  logic           ready;
  logic           hit;
  logic           evict_valid;
  lkt_pkg::key_t  evicted_key;
  lkt_pkg::fill_t fill_count;

  modport source (output valid, output hit, output evict_valid, output evicted_key,
                  output fill_count, input ready);
  modport sink (input valid, input hit, input evict_valid, input evicted_key,
                input fill_count, output ready);
endinterface

FILE: design/lkt_cell.sv
// One slot of the recency chain: holds a key and its valid bit.
module lkt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkt_pkg::bcast_t bcast_i,
  input  lkt_pkg::key_t   prev_key_i,
  input  logic            prev_valid_i,
  input  logic            next_valid_i,
  input  logic            match_up_i,
  input  lkt_pkg::key_t   tail_key_i,
  output lkt_pkg::key_t   key_o,
  output logic            valid_o,
  output logic            match_up_o,
  output lkt_pkg::key_t   tail_key_o
);

  lkt_pkg::key_t key_q, key_d;
  logic          valid_q, valid_d;
  logic          match;
  logic          is_tail;
  logic          shift;

  always_comb begin
    match      = valid_q && (key_q == bcast_i.key);
    match_up_o = match | match_up_i;
    is_tail    = valid_q && !next_valid_i;
    tail_key_o = tail_key_i | (is_tail ? key_q : '0);
    if (bcast_i.hit) begin
      shift = match_up_o;
    end else if (bcast_i.evict) begin
      shift = valid_q;
    end else begin
      shift = valid_q | prev_valid_i;
    end
    key_d   = key_q;
    valid_d = valid_q;
    if (bcast_i.upd && shift) begin
      key_d   = prev_key_i;
      valid_d = prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

FILE: design/lkt_ctrl.sv
// Controller: capacity register, fill count, handshake and result register.
module lkt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  lkt_pkg::cap_t   cfg_wdata_i,
  input  logic            in_valid_i,
  input  lkt_pkg::key_t   in_key_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lkt_pkg::res_t   res_o,
  input  logic            hit_i,
  input  lkt_pkg::key_t   tail_key_i,
  output lkt_pkg::bcast_t bcast_o
);

  lkt_pkg::cap_t cap_q, cap_d;
  lkt_pkg::cnt_t held_q, held_d;
  logic          out_valid_q, out_valid_d;
  lkt_pkg::res_t res_q, res_d;
  lkt_pkg::cnt_t cap_eff;
  logic          accept;
  logic          full;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = lkt_pkg::CntW'(1);
    end else if (32'(cap_q) > lkt_pkg::MaxEntries) begin
      cap_eff = lkt_pkg::CntW'(lkt_pkg::MaxEntries);
    end else begin
      cap_eff = lkt_pkg::CntW'(cap_q);
    end
    full = 32'(held_q) >= 32'(cap_eff);

    in_ready_o = !out_valid_q || out_ready_i;
    accept     = in_valid_i && in_ready_o;

    bcast_o.key   = in_key_i;
    bcast_o.upd   = accept;
    bcast_o.hit   = hit_i;
    bcast_o.evict = !hit_i && full;

    cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

    held_d = held_q;
    if (accept && !hit_i && !full) begin
      held_d = held_q + lkt_pkg::CntW'(1);
    end

    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (accept) begin
      out_valid_d       = 1'b1;
      res_d.hit         = hit_i;
      res_d.evict_valid = bcast_o.evict;
      res_d.evicted_key = bcast_o.evict ? tail_key_i : '0;
      res_d.fill_count  = lkt_pkg::FillW'(held_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkt_pkg::CapReset;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: design/lru_key_tracker_unit.sv
// Top level of the LRU key tracker: a chain of key cells and its controller.
//
//   Channel  Direction  Handshake        Payload
//   in_if    input      valid / ready    ref_key
//   out_if   output     valid / ready    hit, evict_valid, evicted_key, fill_count
//   cfg      input      cfg_we_i         cfg_wdata_i (capacity)
//
// All cells compare and shift in the same cycle,
// and the result appears in the output register on the next cycle.
// A new item is taken every cycle while the output register is empty or drained.
// When the result is stalled, input ready drops until it is taken.
// Reset empties the chain at once; key storage itself is not cleared.
module lru_key_tracker_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  lkt_pkg::cap_t cfg_wdata_i,
  lkt_in_if.sink        in_if,
  lkt_out_if.source     out_if
);

  localparam int unsigned N = lkt_pkg::MaxEntries;

  lkt_pkg::bcast_t bcast;
  lkt_pkg::res_t   res;
  lkt_pkg::key_t   key_w   [N];
  logic            valid_w [N];
  logic            match_w [N+1];
  lkt_pkg::key_t   tail_w  [N+1];

  assign match_w[N] = 1'b0;
  assign tail_w[N]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lkt_pkg::key_t prev_key;
    logic          prev_valid;
    logic          next_valid;

    if (i == 0) begin : g_head
      assign prev_key   = bcast.key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = key_w[i-1];
      assign prev_valid = valid_w[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
    end

    lkt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bcast_i      (bcast),
      .prev_key_i   (prev_key),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .match_up_i   (match_w[i+1]),
      .tail_key_i   (tail_w[i+1]),
      .key_o        (key_w[i]),
      .valid_o      (valid_w[i]),
      .match_up_o   (match_w[i]),
      .tail_key_o   (tail_w[i])
    );
  end

  lkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_if.valid),
    .in_key_i    (in_if.ref_key),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .res_o       (res),
    .hit_i       (match_w[0]),
    .tail_key_i  (tail_w[0]),
    .bcast_o     (bcast)
  );

  assign out_if.hit         = res.hit;
  assign out_if.evict_valid = res.evict_valid;
  assign out_if.evicted_key = res.evicted_key;
  assign out_if.fill_count  = res.fill_count;

endmodule

FILE: design/lkt_chk.sv
// Port-level checker for the LRU key tracker and its bind to the top level.
module lkt_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic           hit_i,
  input logic           evict_valid_i,
  input lkt_pkg::key_t  evicted_key_i,
  input lkt_pkg::fill_t fill_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_i && evict_valid_i))
    else $error("hit reported together with an eviction");

  a_evict_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !evict_valid_i |-> evicted_key_i == '0)
    else $error("evicted key not zero without eviction");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fill_count_i != '0 &&
      32'(fill_count_i) <= lkt_pkg::MaxEntries)
    else $error("fill count out of range");

endmodule

bind lru_key_tracker_unit lkt_chk u_lkt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .hit_i         (out_if.hit),
  .evict_valid_i (out_if.evict_valid),
  .evicted_key_i (out_if.evicted_key),
  .fill_count_i  (out_if.fill_count)
);

FILE: tb/lkt_lru_checker.sv
// Checker that tracks LRU order of referenced keys and compares every result item.
`timescale 1ns / 1ps

module lkt_lru_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lkt_pkg::cap_t     cfg_wdata_i,
  lkt_in_if                 in_mon,
  lkt_out_if                out_mon,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  lkt_pkg::cap_t capacity;
  lkt_pkg::key_t lru_keys [lkt_pkg::MaxEntries];
  int unsigned   held_keys;
  lkt_pkg::res_t expected_res_q [$];
  int unsigned   fails = 0;

  function automatic lkt_pkg::res_t track_ref(input lkt_pkg::key_t key);
    lkt_pkg::res_t r;
    int unsigned   lim;
    int unsigned   pos;
    int unsigned   i;
    bit            found;
    r = '0;
    found = 1'b0;
    pos = 0;
    lim = capacity;
    if (lim == 0) lim = 1;
    if (lim > lkt_pkg::MaxEntries) lim = lkt_pkg::MaxEntries;
    for (i = 0; i < held_keys; i++) begin
      if (!found && lru_keys[i] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (!found) begin
      if (held_keys >= lim && held_keys > 0) begin
        r.evict_valid = 1'b1;
        r.evicted_key = lru_keys[held_keys-1];
        held_keys--;
      end
      pos = held_keys;
      held_keys++;
    end
    for (i = pos; i > 0; i--) lru_keys[i] = lru_keys[i-1];
    lru_keys[0] = key;
    r.hit = found;
    r.fill_count = lkt_pkg::fill_t'(held_keys);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lkt_pkg::res_t want;
    if (!rst_ni) begin
      capacity = lkt_pkg::CapReset;
      held_keys = 0;
      expected_res_q.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_res_q.size() == 0) begin
          fails++;
          $error("Result item arrived with no reference waiting.");
        end else begin
          want = expected_res_q.pop_front();
          check_field("hit", want.hit, out_mon.hit);
          check_field("evict_valid", want.evict_valid, out_mon.evict_valid);
          check_field("evicted_key", want.evicted_key, out_mon.evicted_key);
          check_field("fill_count", want.fill_count, out_mon.fill_count);
        end
      end
      if (in_mon.valid && in_mon.ready) expected_res_q.push_back(track_ref(in_mon.ref_key));
      pending_o <= expected_res_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top that drives key references and capacity writes into the LRU key tracker.
`timescale 1ns / 1ps

module tb_top;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we;
  lkt_pkg::cap_t cfg_wdata;
  bit            steady = 1'b0;
  int unsigned   pending;
  int unsigned   fail_count;

  lkt_in_if  in_ch ();
  lkt_out_if out_ch ();

  lru_key_tracker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  lkt_lru_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  initial begin
    #2000000;
    $display("lru_key_tracker_unit verification failed");
    $finish;
  end

  task automatic send_key(input lkt_pkg::key_t key);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.ref_key <= key;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
    end while (pending != 0 && n < 2000);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input lkt_pkg::cap_t value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pool_n);
    lkt_pkg::key_t pool [$];
    lkt_pkg::key_t k;
    repeat (pool_n) pool.push_back(lkt_pkg::key_t'($urandom));
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, pool_n - 1)];
      else k = lkt_pkg::key_t'($urandom);
      send_key(k);
    end
  endtask

  initial begin
    lkt_pkg::key_t warmup [$];
    lkt_pkg::cap_t cap;
    int unsigned   i;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.ref_key = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme keys, hits at the tail, in the middle and at the tail again, then a fill past the reset capacity.
    warmup = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    for (i = 0; i < 12; i++) warmup.push_back(lkt_pkg::key_t'(32'h5A5A_0000 + i));
    warmup.push_back(32'hA5A5_FFFF);
    warmup.push_back(32'h0000_0000);
    foreach (warmup[j]) send_key(warmup[j]);

    // Capacity lowered below the fill: misses evict one each, a hit evicts nothing.
    write_capacity(lkt_pkg::cap_t'(4));
    send_key(32'h1234_5678);
    send_key(32'hFEDC_BA98);
    send_key(32'h1234_5678);
    run_random(80, 7);

    write_capacity(lkt_pkg::cap_t'(0));
    run_random(60, 3);
    write_capacity(lkt_pkg::cap_t'(1));
    run_random(50, 2);

    write_capacity(lkt_pkg::cap_t'(31));
    steady = 1'b1;
    run_random(100, 22);
    drain();
    steady = 1'b0;

    write_capacity(lkt_pkg::cap_t'(16));
    run_random(120, 20);

    repeat (6) begin
      cap = lkt_pkg::cap_t'($urandom_range(0, 31));
      write_capacity(cap);
      run_random(50, 2 + (cap > 16 ? 16 : cap) + $urandom_range(0, 6));
    end

    drain();
    @(negedge clk_i);
    if (pending != 0) $error("%0d expected result items never arrived.", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("lru_key_tracker_unit verification clean");
    end else begin
      $display("lru_key_tracker_unit verification failed");
    end
    $finish;
  end

endmodule
